FILE: rtl/assert_macros.svh
// Assertion macros shared by the positional insert queue modules.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define PIQ_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// When pre holds, post must hold at the next clock edge.
`define PIQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/piq_pkg.sv
// Shared types and constants for the positional insert queue.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package piq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int MAX_POSITION_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic push;
    logic pop;
    logic flag_empty;
    logic flag_full;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/piq_ctrl.sv
// Controller of the positional insert queue: handshakes and operation decode.
// Depends on piq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module piq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_opcode,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire piq_pkg::stat_t stat,
  output piq_pkg::cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   is_deq;

  // Take a new transaction whenever the result register is free or being drained.
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;
  assign is_deq    = (in_opcode == piq_pkg::OP_DEQUEUE);

  always_comb begin
    cmd.exec       = accept;
    cmd.push       = accept && !is_deq && !stat.full;
    cmd.pop        = accept && is_deq && !stat.empty;
    cmd.flag_empty = accept && is_deq && stat.empty;
    cmd.flag_full  = accept && !is_deq && stat.full;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_nxt = S_HOLD;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PIQ_ASSERT_NOW(a_one_cmd, $onehot0({cmd.push, cmd.pop, cmd.flag_empty, cmd.flag_full}))
  `PIQ_ASSERT_NOW(a_exec_decoded,
    cmd.exec == (cmd.push || cmd.pop || cmd.flag_empty || cmd.flag_full))
  `PIQ_ASSERT_NEXT(a_result_held, cmd.exec, out_valid)

endmodule

`default_nettype wire

FILE: rtl/piq_dp.sv
// Datapath of the positional insert queue: a row of shifting entry cells,
// the occupancy counter and the result registers. Depends on piq_pkg.
`default_nettype none
`include "assert_macros.svh"

module piq_dp #(
  parameter int QUEUE_DEPTH  = piq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_POSITION = piq_pkg::MAX_POSITION_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire piq_pkg::cmd_t                      cmd,
  output piq_pkg::stat_t                          stat,
  input  wire logic signed [piq_pkg::VALUE_W-1:0] in_item_value,
  input  wire logic [piq_pkg::POS_W-1:0]          in_position,
  output logic signed [piq_pkg::VALUE_W-1:0]      out_value,
  output logic [piq_pkg::STATUS_W-1:0]            out_status,
  output logic [piq_pkg::COUNT_W-1:0]             out_entry_count
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = 9;

  logic [piq_pkg::VALUE_W-1:0] cell_r   [QUEUE_DEPTH];
  logic [piq_pkg::VALUE_W-1:0] cell_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic signed [piq_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [piq_pkg::STATUS_W-1:0]       status_r, status_nxt;
  logic [CMP_W-1:0]            pos_ext;
  logic                        insert;
  logic [IDX_W-1:0]            slot;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));

  // Insert in place only inside the queue and within the priority range.
  assign pos_ext = CMP_W'(in_position);
  assign insert  = (pos_ext <= CMP_W'(MAX_POSITION)) && (pos_ext < CMP_W'(count_r));
  assign slot    = insert ? IDX_W'(in_position) : count_r[IDX_W-1:0];

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(gi);
    logic [piq_pkg::VALUE_W-1:0] prev_w, next_w;

    if (gi == 0) begin : g_first
      assign prev_w = in_item_value;
    end else begin : g_prev
      assign prev_w = cell_r[gi-1];
    end
    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign next_w = cell_r[gi];
    end else begin : g_next
      assign next_w = cell_r[gi+1];
    end

    // Each cell holds, loads the new value, moves back or moves forward.
    always_comb begin
      cell_nxt[gi] = cell_r[gi];
      if (cmd.push) begin
        if (CELL_IDX == slot) cell_nxt[gi] = in_item_value;
        else if (CELL_IDX > slot) cell_nxt[gi] = prev_w;
      end else if (cmd.pop) begin
        cell_nxt[gi] = next_w;
      end
    end

    always_ff @(posedge clk) begin
      cell_r[gi] <= cell_nxt[gi];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) count_nxt = count_r + CNT_W'(1);
    else if (cmd.pop) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    value_nxt  = value_r;
    status_nxt = status_r;
    if (cmd.exec) begin
      value_nxt  = cmd.pop ? $signed(cell_r[0]) : '0;
      status_nxt = cmd.flag_empty ? piq_pkg::ST_EMPTY :
                   cmd.flag_full  ? piq_pkg::ST_FULL  : piq_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign out_value       = value_r;
  assign out_status      = status_r;
  assign out_entry_count = piq_pkg::COUNT_W'(count_r);

  `PIQ_ASSERT_NOW(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `PIQ_ASSERT_NEXT(a_pop_dec, cmd.pop, count_r == CNT_W'($past(count_r) - CNT_W'(1)))
  `PIQ_ASSERT_NEXT(a_push_inc, cmd.push, count_r == CNT_W'($past(count_r) + CNT_W'(1)))

endmodule

`default_nettype wire

FILE: rtl/positional_insert_queue.sv
// Positional insert queue:
//   in channel  (in_valid/in_ready): in_opcode, in_item_value, in_position.
//     Opcode 0 enqueues; a position at or below the priority limit and below the
//     current count inserts at that index, anything else appends at the tail.
//     Opcode 1 dequeues the head.
//   out channel (out_valid/out_ready): out_value (dequeued head, else zero),
//     out_status (ok, dequeue on empty, enqueue dropped because full) and
//     out_entry_count (entries after the operation, low five bits).
// Each transaction executes in the cycle it is accepted; its result is valid
// in the next cycle. Throughput is one transaction per cycle while the receiver
// takes results, set by the single output register: the next transaction is
// accepted in the cycle the held result drains. While the receiver stalls,
// the result holds and in_ready stays low. Entries live in a row of cells
// that each load, hold or shift.
// Reset (synchronous, rst_n low) empties the queue; entry contents are not
// cleared. Depends on piq_pkg, piq_ctrl and piq_dp.
`default_nettype none

module positional_insert_queue #(
  parameter int QUEUE_DEPTH  = piq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_POSITION = piq_pkg::MAX_POSITION_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_opcode,
  input  wire logic signed [piq_pkg::VALUE_W-1:0] in_item_value,
  input  wire logic [piq_pkg::POS_W-1:0]          in_position,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [piq_pkg::VALUE_W-1:0]      out_value,
  output logic [piq_pkg::STATUS_W-1:0]            out_status,
  output logic [piq_pkg::COUNT_W-1:0]             out_entry_count
);

  piq_pkg::cmd_t  cmd;
  piq_pkg::stat_t stat;

  piq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  piq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .MAX_POSITION (MAX_POSITION)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_item_value   (in_item_value),
    .in_position     (in_position),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for positional_insert_queue: directed and random enqueue/dequeue
// traffic with random idling on both channels, checked against an in-bench queue predictor.
// Depends on piq_pkg and the positional_insert_queue RTL.
`default_nettype none

module tb_top;

  localparam int DEPTH       = piq_pkg::QUEUE_DEPTH_DEF;
  localparam int MAX_POS     = piq_pkg::MAX_POSITION_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    piq_pkg::opcode_t                   op;
    logic signed [piq_pkg::VALUE_W-1:0] value;
    logic [piq_pkg::POS_W-1:0]          pos;
  } queue_op_t;

  typedef struct {
    logic signed [piq_pkg::VALUE_W-1:0] value;
    piq_pkg::status_t                   status;
    logic [piq_pkg::COUNT_W-1:0]        count;
  } queue_result_t;

  logic                               clk             = 1'b0;
  logic                               rst_n           = 1'b0;
  logic                               in_valid        = 1'b0;
  logic                               in_ready;
  logic                               in_opcode       = 1'b0;
  logic signed [piq_pkg::VALUE_W-1:0] in_item_value   = '0;
  logic [piq_pkg::POS_W-1:0]          in_position     = '0;
  logic                               out_valid;
  logic                               out_ready       = 1'b0;
  logic signed [piq_pkg::VALUE_W-1:0] out_value;
  logic [piq_pkg::STATUS_W-1:0]       out_status;
  logic [piq_pkg::COUNT_W-1:0]        out_entry_count;

  queue_op_t     pending_ops[$];
  queue_result_t due_results[$];
  queue_op_t     shown_op;
  logic signed [piq_pkg::VALUE_W-1:0] shadow_words[DEPTH];
  int            shadow_count   = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            fail_count     = 0;
  int            cycle_count    = 0;

  positional_insert_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always #6 clk = ~clk;

  // Apply one operation to the shadow queue and return the result it produces.
  function automatic queue_result_t queue_apply(queue_op_t op);
    queue_result_t r;
    int            slot;
    r.value  = '0;
    r.status = piq_pkg::ST_OK;
    if (op.op == piq_pkg::OP_DEQUEUE) begin
      if (shadow_count == 0) begin
        r.status = piq_pkg::ST_EMPTY;
      end else begin
        r.value = shadow_words[0];
        for (int i = 1; i < shadow_count; i++) shadow_words[i-1] = shadow_words[i];
        shadow_count--;
      end
    end else if (shadow_count >= DEPTH) begin
      r.status = piq_pkg::ST_FULL;
    end else begin
      slot = shadow_count;
      if (op.pos <= MAX_POS && op.pos < shadow_count) slot = int'(op.pos);
      for (int i = shadow_count; i > slot; i--) shadow_words[i] = shadow_words[i-1];
      shadow_words[slot] = op.value;
      shadow_count++;
    end
    r.count = shadow_count[piq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_op(piq_pkg::opcode_t op, logic [piq_pkg::VALUE_W-1:0] value,
                        logic [piq_pkg::POS_W-1:0] pos);
    queue_op_t t;
    t.op    = op;
    t.value = value;
    t.pos   = pos;
    pending_ops.push_back(t);
  endtask

  // Bursts that mostly fill or mostly drain, so full and empty are both hit often.
  task automatic add_random_ops(int n);
    int                          made;
    int                          burst_len;
    int                          enq_pct;
    int                          kind;
    logic [piq_pkg::VALUE_W-1:0] v;
    logic [piq_pkg::POS_W-1:0]   p;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(9);
      enq_pct = (kind < 4) ? 85 : (kind < 8) ? 15 : 50;
      burst_len = $urandom_range(4, 24);
      for (int i = 0; i < burst_len; i++) begin
        v = $urandom;
        case ($urandom_range(15))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: ;
        endcase
        case ($urandom_range(3))
          0: p = piq_pkg::POS_W'($urandom_range(MAX_POS));
          1: p = piq_pkg::POS_W'($urandom_range(4));
          2: p = piq_pkg::POS_W'($urandom_range(31, MAX_POS + 1));
          default: p = piq_pkg::POS_W'($urandom);
        endcase
        add_op(($urandom_range(99) < enq_pct) ? piq_pkg::OP_ENQUEUE : piq_pkg::OP_DEQUEUE,
               v, p);
        made++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  // Driver: predict on each accepted transaction, then present the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_results.push_back(queue_apply(shown_op));
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_op = pending_ops.pop_front();
          in_valid      <= 1'b1;
          in_opcode     <= shown_op.op;
          in_item_value <= shown_op.value;
          in_position   <= shown_op.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: out_value %0d, out_status %0d, out_entry_count %0d",
               out_value, out_status, out_entry_count);
        fail_count++;
      end else begin
        exp_r = due_results.pop_front();
        if (out_value !== exp_r.value) begin
          $error("out_value: expected %0d, got %0d", exp_r.value, out_value);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("out_status: expected %0d, got %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_entry_count !== exp_r.count) begin
          $error("out_entry_count: expected %0d, got %0d", exp_r.count, out_entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_words[i] = '0;

    // Directed: empty dequeue, head/middle/tail inserts, no-priority appends, full drop.
    add_op(piq_pkg::OP_DEQUEUE, 32'h1234_5678, 5'd0);
    add_op(piq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 5'd31);
    add_op(piq_pkg::OP_ENQUEUE, 32'h8000_0000, 5'd0);
    add_op(piq_pkg::OP_ENQUEUE, 32'h0000_0000, 5'd1);
    add_op(piq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 5'd3);
    add_op(piq_pkg::OP_ENQUEUE, 32'h0000_0011, 5'd16);
    add_op(piq_pkg::OP_ENQUEUE, 32'h0000_0012, 5'd17);
    add_op(piq_pkg::OP_ENQUEUE, 32'h0000_0013, 5'd9);
    add_op(piq_pkg::OP_ENQUEUE, 32'h0000_0014, 5'd2);
    for (int i = 0; i < 8; i++) add_op(piq_pkg::OP_ENQUEUE, 32'hA5A5_0000 + i, 5'(i * 2));
    add_op(piq_pkg::OP_ENQUEUE, 32'h5A5A_5A5A, 5'd0);
    add_op(piq_pkg::OP_ENQUEUE, 32'h5A5A_5A5B, 5'd31);
    add_op(piq_pkg::OP_DEQUEUE, 32'hFFFF_FFFF, 5'd31);
    add_op(piq_pkg::OP_DEQUEUE, 32'h0, 5'd16);
    add_op(piq_pkg::OP_ENQUEUE, 32'h0000_0055, 5'd15);

    send_idle_pct  = 23;
    recv_stall_pct = 86;
    add_random_ops(300);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_quiet();

    send_idle_pct  = 86;
    recv_stall_pct = 23;
    add_random_ops(320);
    wait_quiet();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_ops(330);
    wait_quiet();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
